// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define GABM_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Check a property at every clock edge while reset is held.
`define GABM_ASSERT_IN_RST(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) !rstn_s |-> prop) else $error(msg);

`endif

// File: hdl/gabm_pkg.sv
// ----------------------------------------------------------------------------
// gabm_pkg
// Types and constants of the adjacency bit matrix.
// ----------------------------------------------------------------------------
package gabm_pkg;

    localparam int VERTICES  = 64;
    localparam int IDX_W     = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int ROW_W     = VERTICES;
    localparam int CNT_W     = $clog2(VERTICES + 1);
    localparam int VTX_W     = 8;
    localparam int KIND_W    = 3;
    localparam int NB_W      = 6;
    localparam int CNT_OUT_W = 7;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_QUERY  = 3'd2,
        KIND_LIST   = 3'd3,
        KIND_RMV    = 3'd4,
        KIND_CLEAR  = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [VTX_W-1:0]   src;
        logic [VTX_W-1:0]   tgt;
        logic               bad_add;
    } cmd_t;

    typedef struct packed {
        logic                   reachable;
        logic [NB_W-1:0]        neighbor;
        logic                   has_neighbor;
        logic                   last;
        logic [CNT_OUT_W-1:0]   rows_in_use;
        logic [CNT_OUT_W-1:0]   columns_in_use;
        logic                   error;
    } res_t;

endpackage

// File: hdl/gabm_ram.sv
// ----------------------------------------------------------------------------
// gabm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gabm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/gabm_front.sv
// ----------------------------------------------------------------------------
// gabm_front
// Accepts commands, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module gabm_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gabm_pkg::KIND_W-1:0]    s_tuser,   // kind
    input  logic [2*gabm_pkg::VTX_W-1:0]   s_tdata,   // source_vertex, target_vertex
    output logic                           q_valid,
    output gabm_pkg::cmd_t                 q_cmd,
    input  logic                           q_pop
);

    gabm_pkg::cmd_t                  slot_reg [gabm_pkg::QDEPTH];
    logic [gabm_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [gabm_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [gabm_pkg::QCNT_W-1:0]     cnt_reg;
    gabm_pkg::cmd_t                  cmd_in;
    logic                            push;
    logic                            pop;

    always_comb
    begin
        cmd_in.kind    = gabm_pkg::kind_t'(s_tuser);
        cmd_in.src     = s_tdata[gabm_pkg::VTX_W-1:0];
        cmd_in.tgt     = s_tdata[2*gabm_pkg::VTX_W-1:gabm_pkg::VTX_W];
        // flag an add that names a vertex beyond capacity
        cmd_in.bad_add = (cmd_in.kind == gabm_pkg::KIND_ADD) &&
                         ((cmd_in.src >= gabm_pkg::VTX_W'(gabm_pkg::VERTICES)) ||
                          (cmd_in.tgt >= gabm_pkg::VTX_W'(gabm_pkg::VERTICES)));
    end

    assign s_tready = (cnt_reg != gabm_pkg::QCNT_W'(gabm_pkg::QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_cmd    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/gabm_back.sv
// ----------------------------------------------------------------------------
// gabm_back
// Executes queued commands against the row memory and emits results.
// ----------------------------------------------------------------------------
module gabm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  gabm_pkg::cmd_t       q_cmd,
    output logic                 q_pop,
    output logic                 res_valid,
    input  logic                 res_ready,
    output gabm_pkg::res_t       res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_EXEC,
        S_EMIT,
        S_LIST,
        S_SWP_RD,
        S_SWP_WR
    } state_t;

    state_t                          state_reg, state_next;
    gabm_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [gabm_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [gabm_pkg::CNT_W-1:0]      rows_reg, rows_next;
    logic [gabm_pkg::CNT_W-1:0]      cols_reg, cols_next;
    logic [gabm_pkg::ROW_W-1:0]      valid_reg, valid_next;
    logic [gabm_pkg::IDX_W-1:0]      swp_reg, swp_next;
    logic                            reach_reg, reach_next;
    logic                            err_reg, err_next;
    logic                            ov_reg, ov_next;
    gabm_pkg::res_t                  out_reg, out_next;

    logic                            ram_we;
    logic [gabm_pkg::IDX_W-1:0]      ram_waddr;
    logic [gabm_pkg::ROW_W-1:0]      ram_wdata;
    logic [gabm_pkg::IDX_W-1:0]      ram_raddr;
    logic [gabm_pkg::ROW_W-1:0]      ram_rdata;

    logic [gabm_pkg::IDX_W-1:0]      sidx;
    logic [gabm_pkg::IDX_W-1:0]      tidx;
    logic [gabm_pkg::ROW_W-1:0]      tbit;
    logic [gabm_pkg::ROW_W-1:0]      sbit;
    logic [gabm_pkg::ROW_W-1:0]      col_mask;
    logic [gabm_pkg::ROW_W-1:0]      list_row;
    logic [gabm_pkg::ROW_W-1:0]      rem_row;
    logic [gabm_pkg::IDX_W-1:0]      low_pos;
    logic                            s_lt_rows;
    logic                            s_lt_cols;
    logic                            t_lt_cols;
    logic                            out_free;

    gabm_ram #(
        .WIDTH (gabm_pkg::ROW_W),
        .DEPTH (gabm_pkg::VERTICES)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sidx      = cmd_reg.src[gabm_pkg::IDX_W-1:0];
    assign tidx      = cmd_reg.tgt[gabm_pkg::IDX_W-1:0];
    assign tbit      = gabm_pkg::ROW_W'(1) << tidx;
    assign sbit      = gabm_pkg::ROW_W'(1) << sidx;
    assign s_lt_rows = cmd_reg.src < gabm_pkg::VTX_W'(rows_reg);
    assign s_lt_cols = cmd_reg.src < gabm_pkg::VTX_W'(cols_reg);
    assign t_lt_cols = cmd_reg.tgt < gabm_pkg::VTX_W'(cols_reg);
    assign out_free  = !ov_reg || res_ready;

    always_comb
    begin
        for (int i = 0; i < gabm_pkg::ROW_W; i++)
        begin
            col_mask[i] = (gabm_pkg::CNT_W'(i) < cols_reg);
        end
    end

    // lowest set bit of the pending successor row
    always_comb
    begin
        low_pos = '0;
        for (int i = gabm_pkg::ROW_W - 1; i >= 0; i--)
        begin
            if (row_reg[i])
            begin
                low_pos = gabm_pkg::IDX_W'(i);
            end
        end
        rem_row = row_reg & ~(gabm_pkg::ROW_W'(1) << low_pos);
    end

    assign list_row = s_lt_rows ? (row_reg & col_mask) : '0;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        row_next   = row_reg;
        rows_next  = rows_reg;
        cols_next  = cols_reg;
        valid_next = valid_reg;
        swp_next   = swp_reg;
        reach_next = reach_reg;
        err_next   = err_reg;
        ov_next    = ov_reg && !res_ready;
        out_next   = out_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = sidx;
        ram_wdata  = '0;
        ram_raddr  = q_cmd.src[gabm_pkg::IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                row_next   = valid_reg[sidx] ? ram_rdata : '0;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                reach_next = 1'b0;
                err_next   = 1'b0;
                state_next = S_EMIT;
                unique case (cmd_reg.kind)
                    gabm_pkg::KIND_ADD:
                    begin
                        if (cmd_reg.bad_add)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            ram_we           = 1'b1;
                            ram_wdata        = row_reg | tbit;
                            valid_next[sidx] = 1'b1;
                            if (!s_lt_rows)
                            begin
                                rows_next = gabm_pkg::CNT_W'(cmd_reg.src) + 1'b1;
                            end
                            if (!t_lt_cols)
                            begin
                                cols_next = gabm_pkg::CNT_W'(cmd_reg.tgt) + 1'b1;
                            end
                        end
                    end
                    gabm_pkg::KIND_REMOVE:
                    begin
                        if (s_lt_rows && t_lt_cols)
                        begin
                            ram_we           = 1'b1;
                            ram_wdata        = row_reg & ~tbit;
                            valid_next[sidx] = 1'b1;
                        end
                    end
                    gabm_pkg::KIND_QUERY:
                    begin
                        reach_next = s_lt_rows && t_lt_cols && row_reg[tidx];
                    end
                    gabm_pkg::KIND_LIST:
                    begin
                        row_next = list_row;
                        if (list_row != '0)
                        begin
                            state_next = S_LIST;
                        end
                    end
                    gabm_pkg::KIND_RMV:
                    begin
                        if (s_lt_rows)
                        begin
                            ram_we           = 1'b1;
                            ram_wdata        = '0;
                            valid_next[sidx] = 1'b1;
                        end
                        if (s_lt_cols)
                        begin
                            swp_next   = '0;
                            state_next = S_SWP_RD;
                        end
                    end
                    gabm_pkg::KIND_CLEAR:
                    begin
                        valid_next = '0;
                        rows_next  = '0;
                        cols_next  = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_SWP_RD:
            begin
                ram_raddr  = swp_reg;
                state_next = S_SWP_WR;
            end

            S_SWP_WR:
            begin
                // drop column bit of the removed vertex from this row
                if (valid_reg[swp_reg])
                begin
                    ram_we    = 1'b1;
                    ram_waddr = swp_reg;
                    ram_wdata = ram_rdata & ~sbit;
                end
                if (swp_reg == gabm_pkg::IDX_W'(gabm_pkg::VERTICES - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    swp_next   = swp_reg + 1'b1;
                    state_next = S_SWP_RD;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next                 = 1'b1;
                    out_next.reachable      = reach_reg;
                    out_next.neighbor       = '0;
                    out_next.has_neighbor   = 1'b0;
                    out_next.last           = 1'b1;
                    out_next.rows_in_use    = gabm_pkg::CNT_OUT_W'(rows_reg);
                    out_next.columns_in_use = gabm_pkg::CNT_OUT_W'(cols_reg);
                    out_next.error          = err_reg;
                    state_next              = S_IDLE;
                end
            end

            S_LIST:
            begin
                if (out_free)
                begin
                    ov_next                 = 1'b1;
                    out_next.reachable      = 1'b0;
                    out_next.neighbor       = gabm_pkg::NB_W'(low_pos);
                    out_next.has_neighbor   = 1'b1;
                    out_next.last           = (rem_row == '0);
                    out_next.rows_in_use    = gabm_pkg::CNT_OUT_W'(rows_reg);
                    out_next.columns_in_use = gabm_pkg::CNT_OUT_W'(cols_reg);
                    out_next.error          = 1'b0;
                    row_next                = rem_row;
                    if (rem_row == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rows_reg  <= '0;
            cols_reg  <= '0;
            valid_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            valid_reg <= valid_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        row_reg   <= row_next;
        swp_reg   <= swp_next;
        reach_reg <= reach_next;
        err_reg   <= err_next;
        out_reg   <= out_next;
    end

    assign res_valid = ov_reg;
    assign res       = out_reg;

endmodule

// File: hdl/graph_adjacency_bit_matrix.sv
// ----------------------------------------------------------------------------
// graph_adjacency_bit_matrix
// Directed graph held as a square bit matrix, one memory row per source.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake           Contents
//  s_*      in   s_tvalid/s_tready   tuser kind, tdata source and target
//  m_*      out  m_tvalid/m_tready   tdata result fields, tuser has_neighbor,
//                                    tlast last result of a command
//
//  A command is written into the front queue; the back end then pops it,
//  reads its row, executes it and emits one result for add, remove, query
//  and clear. List emits one result per successor, or one if there is none;
//  remove vertex adds a column sweep that reads each row and rewrites each
//  valid one over the row memory port. Reset clears counts and row valid
//  bits at once; no clearing pass. A stalled m_tready holds the result
//  register; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module graph_adjacency_bit_matrix (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gabm_pkg::KIND_W-1:0]    s_tuser,   // kind
    input  logic [2*gabm_pkg::VTX_W-1:0]   s_tdata,   // source_vertex, target_vertex
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // reachable, neighbor, rows_in_use,
                                                      // columns_in_use, error, zero pad
    output logic                           m_tuser,   // has_neighbor
    output logic                           m_tlast
);

    logic            q_valid;
    logic            q_pop;
    gabm_pkg::cmd_t  q_cmd;
    gabm_pkg::res_t  res;

    gabm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    gabm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {2'b00, res.error, res.columns_in_use, res.rows_in_use,
                      res.neighbor, res.reachable};
    assign m_tuser = res.has_neighbor;
    assign m_tlast = res.last;

endmodule

// File: hdl/gabm_checker.sv
// ----------------------------------------------------------------------------
// gabm_checker
// Port-level checks on the adjacency bit matrix results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gabm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [gabm_pkg::KIND_W-1:0]    s_tuser,
    input  logic [2*gabm_pkg::VTX_W-1:0]   s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [23:0]                    m_tdata,
    input  logic                           m_tuser,
    input  logic                           m_tlast
);

    logic in_xfer;

    assign in_xfer = s_tvalid && s_tready && (s_tuser != '1) && (s_tdata != '1);

    `GABM_ASSERT_IN_RST(a_no_result_in_reset, clk, rst_n, !m_tvalid, "result during reset")

    `GABM_ASSERT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    `GABM_ASSERT(a_plain_is_last, clk, rst_n, m_tvalid && !m_tuser |-> m_tlast, "single result without last")

    `GABM_ASSERT(a_error_clean, clk, rst_n, m_tvalid && m_tdata[21] |-> !m_tdata[0] && !m_tuser, "error result carries data")

    `GABM_ASSERT(a_neighbor_in_cols, clk, rst_n, m_tvalid && m_tuser |-> m_tdata[6:1] < m_tdata[20:14] || in_xfer, "successor beyond column count")

endmodule

bind graph_adjacency_bit_matrix gabm_checker u_gabm_checker (.*);
